/* design/four_carriage_inverse_kinematics_assert.svh */
// assertion macros for the four-carriage inverse kinematics checker
// expects clk and rst_n to be visible where a macro is used
`ifndef FOUR_CARRIAGE_INVERSE_KINEMATICS_ASSERT_SVH
`define FOUR_CARRIAGE_INVERSE_KINEMATICS_ASSERT_SVH

// same-cycle implication
`define FKIK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FKIK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fkik_pkg.sv */
// shared widths, types, register indexes and saturation for the kinematics block
// no dependencies
package fkik_pkg;

  localparam int COORD_W = 24;
  localparam int REG_W   = 23;
  localparam int OUT_W   = 26;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_ARM_LENGTH     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CARRIAGE_OFFSET = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NOZZLE_HEIGHT  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_TRACK     = 2'd3;

  // magnitude of any coordinate difference
  localparam int MAG_W  = ((COORD_W > REG_W + 1) ? COORD_W : REG_W + 1) + 1;
  localparam int DIFF_W = MAG_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ROOT_W = REG_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int OFS_W  = REG_W + 2;
  localparam int SUM_W  = ((COORD_W > OFS_W + 1) ? COORD_W : OFS_W + 1) + 1;

  localparam int MUL_CNT_W  = $clog2(MAG_W + 1);
  localparam int ROOT_CNT_W = $clog2(ROOT_W + 2);

  localparam int IN_TDATA_W  = ((3 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 * OUT_W + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [REG_W-1:0]   reg_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [SQ_W-1:0]    sq_t;
  typedef logic        [RAD_W-1:0]   rad_t;
  typedef logic        [ROOT_W:0]    root_t;
  typedef logic        [OFS_W-1:0]   ofs_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [OUT_W-1:0]   pos_t;

  localparam sum_t SUM_HI = sum_t'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam sum_t SUM_LO = sum_t'(-(64'sd1 <<< (OUT_W - 1)));

  function automatic pos_t sat_out(input sum_t v);
    pos_t s;
    if (v > SUM_HI) begin
      s = pos_t'(SUM_HI);
    end else if (v < SUM_LO) begin
      s = pos_t'(SUM_LO);
    end else begin
      s = pos_t'(v);
    end
    return s;
  endfunction

endpackage

/* design/four_carriage_inverse_kinematics.sv */
// four-carriage inverse kinematics top level: sequencer, squarers, roots, output register
// depends on fkik_pkg, fkik_sqmul, fkik_sqrt
// a word passes the load, bit-serial squarer, subtract, reach check, bit-serial root, sum and
// position states to the output register; an unreachable target goes from the check to the output
// one word in flight: a new input word is taken only after the last result is registered
// synchronous active-low reset clears the state, config registers, reach flag, held positions and output valid
module four_carriage_inverse_kinematics (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fkik_pkg::IN_TDATA_W-1:0]     in_tdata,   // target_x, target_y, target_z
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fkik_pkg::OUT_TDATA_W-1:0]    out_tdata,  // carriage_a, _b, _c, _d
  output logic                                out_tuser,  // reachable
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fkik_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  fkik_pkg::reg_t                      cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_POS  = 3'd7;
  localparam logic [3:0] ST_OUT_UNUSED = 4'd0;

  logic [3:0] state_r, state_nxt;
  localparam logic [3:0] S_IDLE = {1'b0, ST_IDLE};
  localparam logic [3:0] S_LOAD = {1'b0, ST_LOAD};
  localparam logic [3:0] S_SQ   = {1'b0, ST_SQ};
  localparam logic [3:0] S_SUB  = {1'b0, ST_SUB};
  localparam logic [3:0] S_CHK  = {1'b0, ST_CHK};
  localparam logic [3:0] S_ROOT = {1'b0, ST_ROOT};
  localparam logic [3:0] S_SUM  = {1'b0, ST_SUM};
  localparam logic [3:0] S_POS  = {1'b0, ST_POS};
  localparam logic [3:0] S_OUT  = ST_OUT_UNUSED | 4'd8;

  fkik_pkg::reg_t arm_r, off_r, nh_r, ht_r;
  fkik_pkg::coord_t tx, ty, tz;
  fkik_pkg::coord_t x_r;
  fkik_pkg::diff_t  dz_r, dy0_r, dy1_r;
  fkik_pkg::diff_t  dz_nxt, dy0_nxt, dy1_nxt;
  logic [fkik_pkg::SQ_W:0] a_r, a_nxt, t0, t1;
  logic reach_r, reach_nxt, ok;
  fkik_pkg::ofs_t d0_r, d1_r;
  fkik_pkg::pos_t pos_r [4];
  fkik_pkg::sum_t sx, sd0, sd1;

  logic out_valid_r, out_valid_nxt;
  logic [fkik_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic out_user_r;

  logic mul_start, root_start;
  logic [3:0] mul_done;
  fkik_pkg::sq_t sq_arm, sq_dz, sq_dy0, sq_dy1;
  logic [1:0] root_done;
  fkik_pkg::root_t root0, root1;
  fkik_pkg::rad_t rad0, rad1;
  logic in_acc, out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign tx = fkik_pkg::coord_t'(in_tdata[fkik_pkg::COORD_W-1:0]);
  assign ty = fkik_pkg::coord_t'(in_tdata[2*fkik_pkg::COORD_W-1:fkik_pkg::COORD_W]);
  assign tz = fkik_pkg::coord_t'(in_tdata[3*fkik_pkg::COORD_W-1:2*fkik_pkg::COORD_W]);

  // signed differences: dz = z - h, dy0 = r - t - y, dy1 = t - y - r
  always_comb begin
    dz_nxt  = fkik_pkg::diff_t'(tz) - fkik_pkg::diff_t'(nh_r);
    dy0_nxt = fkik_pkg::diff_t'(off_r) - fkik_pkg::diff_t'(ht_r) - fkik_pkg::diff_t'(ty);
    dy1_nxt = fkik_pkg::diff_t'(ht_r) - fkik_pkg::diff_t'(ty) - fkik_pkg::diff_t'(off_r);
  end

  assign mul_start = (state_r == S_LOAD);

  fkik_sqmul u_mul_arm (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .operand(fkik_pkg::diff_t'(arm_r)),
    .done(mul_done[0]), .product(sq_arm)
  );
  fkik_sqmul u_mul_dz (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .operand(dz_r),
    .done(mul_done[1]), .product(sq_dz)
  );
  fkik_sqmul u_mul_dy0 (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .operand(dy0_r),
    .done(mul_done[2]), .product(sq_dy0)
  );
  fkik_sqmul u_mul_dy1 (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .operand(dy1_r),
    .done(mul_done[3]), .product(sq_dy1)
  );

  // reach check: borrow bits flag negative radicands
  always_comb begin
    a_nxt = {1'b0, sq_arm} - {1'b0, sq_dz};
    t0    = {1'b0, a_r[fkik_pkg::SQ_W-1:0]} - {1'b0, sq_dy0};
    t1    = {1'b0, a_r[fkik_pkg::SQ_W-1:0]} - {1'b0, sq_dy1};
    ok    = !a_r[fkik_pkg::SQ_W] && !t0[fkik_pkg::SQ_W] && !t1[fkik_pkg::SQ_W];
    rad0  = t0[fkik_pkg::RAD_W-1:0];
    rad1  = t1[fkik_pkg::RAD_W-1:0];
  end

  assign root_start = (state_r == S_CHK) && ok;

  fkik_sqrt u_root0 (
    .clk(clk), .rst_n(rst_n), .start(root_start), .radicand(rad0),
    .done(root_done[0]), .root(root0)
  );
  fkik_sqrt u_root1 (
    .clk(clk), .rst_n(rst_n), .start(root_start), .radicand(rad1),
    .done(root_done[1]), .root(root1)
  );

  always_comb begin
    sx  = fkik_pkg::sum_t'(x_r);
    sd0 = fkik_pkg::sum_t'(d0_r);
    sd1 = fkik_pkg::sum_t'(d1_r);
  end

  always_comb begin
    state_nxt     = state_r;
    reach_nxt     = reach_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (&mul_done) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        reach_nxt = ok;
        state_nxt = ok ? S_ROOT : S_OUT;
      end
      S_ROOT: begin
        if (&root_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = S_POS;
      end
      S_POS: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      reach_r     <= 1'b0;
      arm_r       <= '0;
      off_r       <= '0;
      nh_r        <= '0;
      ht_r        <= '0;
      for (int i = 0; i < 4; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      reach_r     <= reach_nxt;
      if (cfg_valid) begin
        case (cfg_addr)
          fkik_pkg::REG_ARM_LENGTH:      arm_r <= cfg_data;
          fkik_pkg::REG_CARRIAGE_OFFSET: off_r <= cfg_data;
          fkik_pkg::REG_NOZZLE_HEIGHT:   nh_r  <= cfg_data;
          fkik_pkg::REG_HALF_TRACK:      ht_r  <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_POS) begin
        pos_r[0] <= fkik_pkg::sat_out(sx - sd0);
        pos_r[1] <= fkik_pkg::sat_out(sx + sd0);
        pos_r[2] <= fkik_pkg::sat_out(sx + sd1);
        pos_r[3] <= fkik_pkg::sat_out(sx - sd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= tx;
      dz_r  <= dz_nxt;
      dy0_r <= dy0_nxt;
      dy1_r <= dy1_nxt;
    end
    if (state_r == S_SUB) begin
      a_r <= a_nxt;
    end
    if (state_r == S_SUM) begin
      d0_r <= fkik_pkg::ofs_t'(off_r) + fkik_pkg::ofs_t'(root0);
      d1_r <= fkik_pkg::ofs_t'(off_r) + fkik_pkg::ofs_t'(root1);
    end
    if ((state_r == S_OUT) && out_free) begin
      out_data_r <= fkik_pkg::OUT_TDATA_W'({pos_r[3], pos_r[2], pos_r[1], pos_r[0]});
      out_user_r <= reach_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* design/fkik_sqmul.sv */
// bit-serial squarer: magnitude of a signed difference, one multiplier bit per cycle
// depends on fkik_pkg
module fkik_sqmul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fkik_pkg::diff_t   operand,
  output logic              done,
  output fkik_pkg::sq_t     product
);

  logic [fkik_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  fkik_pkg::mag_t mcand_r, mcand_nxt;
  fkik_pkg::mag_t mplier_r, mplier_nxt;
  fkik_pkg::sq_t  acc_r, acc_nxt;
  fkik_pkg::mag_t mag;
  fkik_pkg::diff_t neg;

  always_comb begin
    neg = -operand;
    mag = operand[fkik_pkg::DIFF_W-1] ? fkik_pkg::mag_t'(neg) : fkik_pkg::mag_t'(operand);
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    if (start) begin
      cnt_nxt    = fkik_pkg::MUL_CNT_W'(fkik_pkg::MAG_W);
      mcand_nxt  = mag;
      mplier_nxt = mag;
      acc_nxt    = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt    = cnt_r - fkik_pkg::MUL_CNT_W'(1);
      mplier_nxt = {mplier_r[fkik_pkg::MAG_W-2:0], 1'b0};
      acc_nxt    = {acc_r[fkik_pkg::SQ_W-2:0], 1'b0}
                 + (mplier_r[fkik_pkg::MAG_W-1] ? fkik_pkg::sq_t'(mcand_r) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign done    = (cnt_r == '0);
  assign product = acc_r;

endmodule

/* design/fkik_sqrt.sv */
// digit-by-digit square root, one result bit per cycle, rounded to nearest
// depends on fkik_pkg
module fkik_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fkik_pkg::rad_t    radicand,
  output logic              done,
  output fkik_pkg::root_t   root
);

  logic [fkik_pkg::ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  fkik_pkg::rad_t  rad_r, rad_nxt;
  logic [fkik_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [fkik_pkg::REM_W-1:0] rem_sh, trial;
  logic [fkik_pkg::ROOT_W-1:0] q_r, q_nxt;
  fkik_pkg::root_t root_r, root_nxt;
  logic ge;

  always_comb begin
    rem_sh = {rem_r[fkik_pkg::REM_W-3:0], rad_r[fkik_pkg::RAD_W-1 -: 2]};
    trial  = fkik_pkg::REM_W'({q_r, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    root_nxt = root_r;
    if (start) begin
      cnt_nxt = fkik_pkg::ROOT_CNT_W'(fkik_pkg::ROOT_W + 1);
      rad_nxt = radicand;
      rem_nxt = '0;
      q_nxt   = '0;
    end else if (cnt_r == fkik_pkg::ROOT_CNT_W'(1)) begin
      // round up when the remainder exceeds the floor root
      cnt_nxt  = '0;
      root_nxt = fkik_pkg::root_t'(q_r)
               + fkik_pkg::root_t'(rem_r > fkik_pkg::REM_W'(q_r));
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - fkik_pkg::ROOT_CNT_W'(1);
      rad_nxt = {rad_r[fkik_pkg::RAD_W-3:0], 2'b00};
      rem_nxt = ge ? rem_sh - trial : rem_sh;
      q_nxt   = {q_r[fkik_pkg::ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    root_r <= root_nxt;
  end

  assign done = (cnt_r == '0);
  assign root = root_r;

endmodule

/* design/fkik_chk.sv */
// port-level checker for the kinematics block, bound to the top level
// depends on fkik_pkg and four_carriage_inverse_kinematics_assert.svh
`include "four_carriage_inverse_kinematics_assert.svh"

module fkik_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [fkik_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                                out_tuser,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  // stalled result word holds
  `FKIK_ASSERT_NEXT(a_out_hold, rst_n && out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  // one word in flight at a time
  `FKIK_ASSERT_NEXT(a_single_item, rst_n && in_tvalid && in_tready, !in_tready, "input taken while busy")

  // no result can appear right after a word is taken
  `FKIK_ASSERT_NEXT(a_no_early_result, rst_n && in_tvalid && in_tready, !$rose(out_tvalid), "result too early")

  // config writes never stall
  `FKIK_ASSERT_NOW(a_cfg_ready, rst_n && cfg_valid, cfg_ready, "config write stalled")

endmodule

bind four_carriage_inverse_kinematics fkik_chk u_fkik_chk (.*);

/* tb/four_carriage_inverse_kinematics_tb.sv */
// self-checking testbench for four_carriage_inverse_kinematics: directed and random targets
// scoreboard class predicts carriage positions and the reachable flag from the register settings
// depends on fkik_pkg and the four_carriage_inverse_kinematics rtl
module four_carriage_inverse_kinematics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESULT_LATENCY = 57;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 154;

  localparam fkik_pkg::coord_t C_MAX = {1'b0, {(fkik_pkg::COORD_W-1){1'b1}}};
  localparam fkik_pkg::coord_t C_MIN = {1'b1, {(fkik_pkg::COORD_W-1){1'b0}}};
  localparam fkik_pkg::reg_t   R_MAX = '1;

  typedef struct {
    fkik_pkg::pos_t a;
    fkik_pkg::pos_t b;
    fkik_pkg::pos_t c;
    fkik_pkg::pos_t d;
    logic reach;
  } carriage_set_t;

  class carriage_scoreboard;
    fkik_pkg::reg_t arm_len;
    fkik_pkg::reg_t ofs;
    fkik_pkg::reg_t nozzle;
    fkik_pkg::reg_t track;
    fkik_pkg::pos_t held[4];
    carriage_set_t expected_sets[$];
    int mismatches;

    function new();
      arm_len = '0;
      ofs = '0;
      nozzle = '0;
      track = '0;
      foreach (held[i]) held[i] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [fkik_pkg::CFG_ADDR_W-1:0] idx, fkik_pkg::reg_t val);
      case (idx)
        fkik_pkg::REG_ARM_LENGTH:      arm_len = val;
        fkik_pkg::REG_CARRIAGE_OFFSET: ofs = val;
        fkik_pkg::REG_NOZZLE_HEIGHT:   nozzle = val;
        fkik_pkg::REG_HALF_TRACK:      track = val;
        default: ;
      endcase
    endfunction

    function longint unsigned mag_sq(longint v);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      return m * m;
    endfunction

    function longint unsigned root_nearest(longint unsigned u);
      longint unsigned s;
      longint unsigned t;
      s = 0;
      for (int i = 31; i >= 0; i--) begin
        t = s | (64'd1 << i);
        if (t * t <= u) s = t;
      end
      if (u - s * s > s) s = s + 1;
      return s;
    endfunction

    function fkik_pkg::pos_t clamp_pos(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (fkik_pkg::OUT_W - 1)) - 1;
      lo = -(longint'(1) <<< (fkik_pkg::OUT_W - 1));
      if (v > hi) return fkik_pkg::pos_t'(hi);
      if (v < lo) return fkik_pkg::pos_t'(lo);
      return fkik_pkg::pos_t'(v);
    endfunction

    function void note_target(fkik_pkg::coord_t x, fkik_pkg::coord_t y, fkik_pkg::coord_t z);
      longint sx, sy, sz, r, t, d0, d1;
      longint unsigned r2, dz2, dy0, dy1;
      bit ok;
      carriage_set_t e;
      sx = x;
      sy = y;
      sz = z;
      r = longint'(ofs);
      t = longint'(track);
      r2 = longint'(arm_len) * longint'(arm_len);
      dz2 = mag_sq(sz - longint'(nozzle));
      dy0 = mag_sq(-t - (sy - r));
      dy1 = mag_sq(t - (sy + r));
      ok = (dz2 <= r2) && (dy0 <= r2 - dz2) && (dy1 <= r2 - dz2);
      if (ok) begin
        d0 = r + longint'(root_nearest(r2 - dz2 - dy0));
        d1 = r + longint'(root_nearest(r2 - dz2 - dy1));
        held[0] = clamp_pos(sx - d0);
        held[1] = clamp_pos(sx + d0);
        held[2] = clamp_pos(sx + d1);
        held[3] = clamp_pos(sx - d1);
      end
      e.a = held[0];
      e.b = held[1];
      e.c = held[2];
      e.d = held[3];
      e.reach = ok;
      expected_sets.push_back(e);
    endfunction

    function void report(string field, longint exp_v, longint act_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
    endfunction

    function void check_carriages(carriage_set_t got);
      carriage_set_t e;
      if (expected_sets.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none actual %0d %0d %0d %0d %0b",
                 $time, got.a, got.b, got.c, got.d, got.reach);
        return;
      end
      e = expected_sets.pop_front();
      if (got.a !== e.a) report("carriage_a", e.a, got.a);
      if (got.b !== e.b) report("carriage_b", e.b, got.b);
      if (got.c !== e.c) report("carriage_c", e.c, got.c);
      if (got.d !== e.d) report("carriage_d", e.d, got.d);
      if (got.reach !== e.reach) report("reachable", e.reach, got.reach);
    endfunction

    function int pending();
      return expected_sets.size();
    endfunction
  endclass

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   in_tvalid = 1'b0;
  logic                                   in_tready;
  logic [fkik_pkg::IN_TDATA_W-1:0]        in_tdata = '0;
  logic                                   out_tvalid;
  logic                                   out_tready = 1'b0;
  logic [fkik_pkg::OUT_TDATA_W-1:0]       out_tdata;
  logic                                   out_tuser;
  logic                                   cfg_valid = 1'b0;
  logic                                   cfg_ready;
  logic [fkik_pkg::CFG_ADDR_W-1:0]        cfg_addr = '0;
  fkik_pkg::reg_t                         cfg_data = '0;

  carriage_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_cycles = 0;

  four_carriage_inverse_kinematics DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("four_carriage_inverse_kinematics_tb failed");
      $finish;
    end
  end

  task automatic send_target(fkik_pkg::coord_t x, fkik_pkg::coord_t y, fkik_pkg::coord_t z);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= fkik_pkg::IN_TDATA_W'({z, y, x});
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_target(x, y, z);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(logic [fkik_pkg::CFG_ADDR_W-1:0] idx, fkik_pkg::reg_t val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(fkik_pkg::reg_t arm, fkik_pkg::reg_t ofs, fkik_pkg::reg_t nh,
                              fkik_pkg::reg_t ht);
    cfg_put(fkik_pkg::REG_ARM_LENGTH, arm);
    cfg_put(fkik_pkg::REG_CARRIAGE_OFFSET, ofs);
    cfg_put(fkik_pkg::REG_NOZZLE_HEIGHT, nh);
    cfg_put(fkik_pkg::REG_HALF_TRACK, ht);
    cfg_valid <= 1'b0;
  endtask

  function automatic fkik_pkg::coord_t clamp_coord(longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return fkik_pkg::coord_t'(v);
  endfunction

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  task automatic send_random_target();
    fkik_pkg::coord_t x, y, z;
    longint span;
    x = fkik_pkg::coord_t'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      span = (longint'(sb.arm_len) * 3) / 4 + 1;
      z = clamp_coord(longint'(sb.nozzle) + spread(span));
      y = clamp_coord(spread(longint'(sb.arm_len) / 4 + 1));
    end else begin
      y = fkik_pkg::coord_t'($urandom);
      z = fkik_pkg::coord_t'($urandom);
    end
    send_target(x, y, z);
  endtask

  task automatic program_random_regs(int kind);
    fkik_pkg::reg_t arm;
    case (kind)
      0: program_regs(fkik_pkg::reg_t'($urandom), fkik_pkg::reg_t'($urandom),
                      fkik_pkg::reg_t'($urandom), fkik_pkg::reg_t'($urandom));
      1: program_regs(R_MAX, R_MAX, R_MAX, R_MAX);
      2: program_regs(fkik_pkg::reg_t'($urandom_range(0, 255)), '0, '0, '0);
      default: begin
        arm = fkik_pkg::reg_t'($urandom_range(1 << 18, (1 << fkik_pkg::REG_W) - 1));
        program_regs(arm, fkik_pkg::reg_t'($urandom_range(0, arm / 4)),
                     fkik_pkg::reg_t'($urandom),
                     fkik_pkg::reg_t'($urandom_range(0, arm / 4)));
      end
    endcase
  endtask

  // result side: random stalls outside quiet phases, one word per pass
  initial begin
    carriage_set_t got;
    int gap;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.a = fkik_pkg::pos_t'(out_tdata[0 +: fkik_pkg::OUT_W]);
      got.b = fkik_pkg::pos_t'(out_tdata[fkik_pkg::OUT_W +: fkik_pkg::OUT_W]);
      got.c = fkik_pkg::pos_t'(out_tdata[2*fkik_pkg::OUT_W +: fkik_pkg::OUT_W]);
      got.d = fkik_pkg::pos_t'(out_tdata[3*fkik_pkg::OUT_W +: fkik_pkg::OUT_W]);
      got.reach = out_tuser;
      sb.check_carriages(got);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero arm, only the origin line is reachable
    send_target('0, '0, '0);
    send_target(fkik_pkg::coord_t'(1), '0, '0);
    send_target(fkik_pkg::coord_t'(5), fkik_pkg::coord_t'(1), '0);
    send_target(C_MIN, '0, '0);
    send_target(C_MAX, '0, '0);
    drain_results();

    // longest arm, no offsets: corner targets, zero radicand, held positions
    program_regs(R_MAX, '0, '0, '0);
    send_target(C_MAX, C_MAX, C_MAX);
    send_target(C_MIN, C_MIN, C_MIN);
    send_target('0, '0, '0);
    send_target(C_MAX, '0, '0);
    send_target(C_MIN, '0, '0);
    send_target('0, fkik_pkg::coord_t'(1 << 22), '0);
    send_target('0, '0, C_MIN + fkik_pkg::coord_t'(1));
    send_target(C_MAX, fkik_pkg::coord_t'(1), C_MIN + fkik_pkg::coord_t'(1));
    drain_results();

    // every register at its top value
    program_regs(R_MAX, R_MAX, R_MAX, R_MAX);
    send_target(C_MAX, '0, C_MAX);
    send_target(C_MIN, '0, C_MAX);
    send_target('0, '0, '0);
    send_target(C_MIN, C_MAX, C_MIN);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      program_random_regs((p == 0) ? 3 : $urandom_range(0, 4));
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_target();
        if ($urandom_range(0, 59) == 0) drain_results();
      end
    end

    drain_results();
    repeat (2 * RESULT_LATENCY) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("four_carriage_inverse_kinematics_tb passed");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected words never arrived", $time, sb.pending());
      $display("four_carriage_inverse_kinematics_tb failed");
    end
    $finish;
  end

endmodule
